// ===== rtl/lav_pkg.sv =====
`timescale 1ns / 1ps

package lav_pkg;

	localparam int DEF_QUEUE_DEPTH = 2;

	localparam int FW = 32;          // Q16.16 field
	localparam int DW = FW + 1;      // target - eye, exact
	localparam int NW = 18;          // unit vector entry, |x| <= 1.0
	localparam int VW = 50;          // normaliser input, holds f x up
	localparam int MW = VW - 1;      // magnitude of a normaliser input
	localparam int PW = NW + DW;     // one product
	localparam int AW = PW + 2;      // sum of up to three products
	localparam int RW = AW - 15;     // Q21.32 rounded to Q22.16

	localparam logic [1:0] ROW_LAST = 2'd3;

	typedef logic signed [FW-1:0] q16_t;
	typedef logic signed [NW-1:0] unit_t;

	localparam q16_t ONE_Q16 = 32'sh0001_0000;
	localparam q16_t Q16_MAX = 32'sh7fff_ffff;
	localparam q16_t Q16_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [2:0][FW-1:0] eye;
		logic [2:0][FW-1:0] up;
		logic [2:0][DW-1:0] d;
		logic               fwd_zero;
	} lav_job_t;

	typedef struct packed {
		logic               done;
		logic               zero;
		logic [2:0][NW-1:0] n;
	} lav_norm_res_t;

	// Q21.32 -> Q22.16, half away from zero
	function automatic logic signed [RW-1:0] round_q16(input logic signed [AW-1:0] x);
		logic [AW-1:0] m;
		logic [AW-1:0] r;
		m = x[AW-1] ? AW'(-x) : AW'(x);
		r = (m + AW'(32768)) >> 16;
		round_q16 = x[AW-1] ? -$signed(RW'(r)) : $signed(RW'(r));
	endfunction

	function automatic q16_t sat_q16(input logic signed [RW-1:0] x);
		if (x[RW-1:FW-1] == '0 || x[RW-1:FW-1] == '1)
			sat_q16 = $signed(x[FW-1:0]);
		else if (x[RW-1])
			sat_q16 = Q16_MIN;
		else
			sat_q16 = Q16_MAX;
	endfunction

endpackage

// ===== rtl/lav_if.sv =====
`timescale 1ns / 1ps

interface lav_in_if import lav_pkg::*; ();
	logic valid;
	logic ready;
	q16_t eye_x;
	q16_t eye_y;
	q16_t eye_z;
	q16_t up_x;
	q16_t up_y;
	q16_t up_z;
	q16_t target_x;
	q16_t target_y;
	q16_t target_z;

	modport source (output valid, eye_x, eye_y, eye_z, up_x, up_y, up_z,
		target_x, target_y, target_z, input ready);
	modport sink (input valid, eye_x, eye_y, eye_z, up_x, up_y, up_z,
		target_x, target_y, target_z, output ready);
endinterface

interface lav_out_if import lav_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] row_index;
	q16_t       col0;
	q16_t       col1;
	q16_t       col2;
	q16_t       col3;
	logic       degenerate;
	logic       last;

	modport source (output valid, row_index, col0, col1, col2, col3, degenerate, last,
		input ready);
	modport sink (input valid, row_index, col0, col1, col2, col3, degenerate, last,
		output ready);
endinterface

// ===== rtl/look_at_view_matrix_top.sv =====
`timescale 1ns / 1ps

// Look-at view matrix, signed Q16.16 in and out. Each beat on cmd (eye, up,
// target) gives four beats on mat: rows 0..2 carry r, u and -f with the
// translation -dot(row, eye) in col3, row 3 is 0 0 0 1.0 with last set. A zero
// forward or right vector flags degenerate and zeroes rows 0..2. A thin front
// stage forms target - eye and spots eye-on-target, a small queue holds jobs,
// and the back end works one job at a time; its time per job is set by the
// bit-serial normaliser (a 31-step square root and three 17-step divisions, run
// once for f and once for r), and eye-on-target jobs skip the normaliser. cmd
// keeps accepting while the back end is busy until queue and front register are full.
// No configuration; no clearing pass after reset.

module look_at_view_matrix_top import lav_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	lav_in_if.sink    cmd,
	lav_out_if.source mat
);

	logic     fr_valid;
	lav_job_t fr_job;
	logic     fr_ready;
	logic     bk_valid;
	lav_job_t bk_job;
	logic     bk_pop;

	// target - eye, eye-on-target check
	lav_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.job_valid (fr_valid),
		.job       (fr_job),
		.job_ready (fr_ready)
	);

	lav_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fr_valid),
		.push_job   (fr_job),
		.push_ready (fr_ready),
		.pop_valid  (bk_valid),
		.pop_job    (bk_job),
		.pop        (bk_pop)
	);

	// normalise, cross products, translation, row output register
	lav_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bk_valid),
		.job       (bk_job),
		.job_pop   (bk_pop),
		.mat       (mat)
	);

endmodule

// ===== rtl/lav_norm.sv =====
`timescale 1ns / 1ps

module lav_norm import lav_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0][VW-1:0] v,
	output lav_norm_res_t      res
);

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_ROOT  = 3'd3;
	localparam logic [2:0] N_LOAD  = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;

	localparam int AIW   = 30;          // magnitude after scaling
	localparam int SW    = 2 * AIW;
	localparam int SUMW  = SW + 2;
	localparam int ROOTW = SUMW + 1;
	localparam int LW    = 31;
	localparam int NUMW  = LW + 17;
	localparam int QW    = 17;
	localparam int ROOT_STEPS = SUMW / 2;
	localparam int DIV_STEPS  = QW;

	logic [2:0]       state_q;
	logic [5:0]       cnt_q;
	logic [4:0]       step_q;
	logic [1:0]       comp_q;
	logic             done_q;
	logic             zero_q;
	logic [MW-1:0]    a_q [3];
	logic [2:0]       neg_q;
	logic [SW-1:0]    sq_s1;
	logic [SUMW-1:0]  acc_q;
	logic [SUMW-1:0]  rem_q;
	logic [ROOTW-1:0] root_q;
	logic [ROOTW-1:0] bit_q;
	logic [LW-1:0]    len_q;
	logic [NUMW-1:0]  drem_q;
	logic [NUMW-1:0]  dsh_q;
	logic [QW-1:0]    quo_q;
	unit_t            n_q [3];

	logic [MW-1:0]    mag_in [3];
	logic             all_zero;
	logic             big;
	logic             small_m;
	logic [AIW-1:0]   asel;
	logic [AIW-1:0]   acomp;
	logic [ROOTW-1:0] trial;
	logic             rge;
	logic [ROOTW-1:0] root_nx;
	logic             dge;
	logic [QW-1:0]    quo_nx;

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_in[i] = v[i][VW-1] ? MW'(-$signed(v[i])) : MW'(v[i]);
		all_zero = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
		big      = (|a_q[0][MW-1:AIW]) | (|a_q[1][MW-1:AIW]) | (|a_q[2][MW-1:AIW]);
		small_m  = !((|a_q[0][MW-1:AIW-1]) | (|a_q[1][MW-1:AIW-1])
			| (|a_q[2][MW-1:AIW-1]));
		case (cnt_q[1:0])
			2'd0:    asel = a_q[0][AIW-1:0];
			2'd1:    asel = a_q[1][AIW-1:0];
			default: asel = a_q[2][AIW-1:0];
		endcase
		case (comp_q)
			2'd0:    acomp = a_q[0][AIW-1:0];
			2'd1:    acomp = a_q[1][AIW-1:0];
			default: acomp = a_q[2][AIW-1:0];
		endcase
		trial   = root_q + bit_q;
		rge     = {1'b0, rem_q} >= trial;
		root_nx = rge ? (root_q >> 1) + bit_q : root_q >> 1;
		dge     = drem_q >= dsh_q;
		quo_nx  = {quo_q[QW-2:0], dge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			comp_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						if (all_zero)
							done_q <= 1'b1;
						else
							state_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (!big && !small_m) begin
						state_q <= N_SQ;
						cnt_q   <= '0;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						state_q <= N_ROOT;
						cnt_q   <= '0;
					end
				end
				N_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(ROOT_STEPS - 1)) begin
						state_q <= N_LOAD;
						comp_q  <= '0;
					end
				end
				N_LOAD: begin
					state_q <= N_DIV;
					step_q  <= '0;
				end
				N_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DIV_STEPS - 1)) begin
						if (comp_q == 2'd2) begin
							state_q <= N_IDLE;
							done_q  <= 1'b1;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= N_LOAD;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						a_q[i]   <= mag_in[i];
						neg_q[i] <= v[i][VW-1];
					end
					zero_q <= all_zero;
					if (all_zero)
						for (int i = 0; i < 3; i++)
							n_q[i] <= '0;
				end
			end
			N_SHIFT: begin
				// common scale: largest magnitude into [2^29, 2^30)
				for (int i = 0; i < 3; i++) begin
					if (big)
						a_q[i] <= a_q[i] >> 1;
					else if (small_m)
						a_q[i] <= a_q[i] << 1;
				end
			end
			N_SQ: begin
				sq_s1 <= asel * asel;
				if (cnt_q == 6'd0)
					acc_q <= '0;
				else
					acc_q <= acc_q + SUMW'(sq_s1);
				if (cnt_q == 6'd3) begin
					rem_q  <= acc_q + SUMW'(sq_s1);
					root_q <= '0;
					bit_q  <= ROOTW'(1) << (SUMW - 2);
				end
			end
			N_ROOT: begin
				if (rge)
					rem_q <= rem_q - trial[SUMW-1:0];
				root_q <= root_nx;
				bit_q  <= bit_q >> 2;
				if (cnt_q == 6'(ROOT_STEPS - 1))
					len_q <= root_nx[LW-1:0];
			end
			N_LOAD: begin
				drem_q <= NUMW'({acomp, 16'b0}) + NUMW'(len_q >> 1);
				dsh_q  <= NUMW'({len_q, 16'b0});
				quo_q  <= '0;
			end
			N_DIV: begin
				if (dge)
					drem_q <= drem_q - dsh_q;
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_nx;
				if (step_q == 5'(DIV_STEPS - 1))
					n_q[comp_q] <= neg_q[comp_q] ? -$signed(NW'(quo_nx))
						: $signed(NW'(quo_nx));
			end
			default: ;
		endcase
	end

	always_comb begin
		res.done = done_q;
		res.zero = zero_q;
		for (int i = 0; i < 3; i++)
			res.n[i] = n_q[i];
	end

endmodule

// ===== rtl/lav_queue.sv =====
`timescale 1ns / 1ps

module lav_queue import lav_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  lav_job_t push_job,
	output logic     push_ready,
	output logic     pop_valid,
	output lav_job_t pop_job,
	input  logic     pop
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);

	lav_job_t        mem_q [DEPTH];
	logic [PTRW-1:0] wr_q;
	logic [PTRW-1:0] rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + PTRW'(1);
			if (do_pop)
				rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + PTRW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_job;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue fill beyond depth");

	a_fill_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("queue fill did not follow push");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

endmodule

// ===== rtl/lav_front.sv =====
`timescale 1ns / 1ps

module lav_front import lav_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	lav_in_if.sink   cmd,
	output logic     job_valid,
	output lav_job_t job,
	input  logic     job_ready
);

	logic     v_s1;
	lav_job_t job_s1;
	lav_job_t job_c;

	assign cmd.ready = !v_s1 || job_ready;
	assign job_valid = v_s1;
	assign job       = job_s1;

	always_comb begin
		job_c.eye  = {cmd.eye_z, cmd.eye_y, cmd.eye_x};
		job_c.up   = {cmd.up_z, cmd.up_y, cmd.up_x};
		job_c.d[0] = $signed({cmd.target_x[FW-1], cmd.target_x})
			- $signed({cmd.eye_x[FW-1], cmd.eye_x});
		job_c.d[1] = $signed({cmd.target_y[FW-1], cmd.target_y})
			- $signed({cmd.eye_y[FW-1], cmd.eye_y});
		job_c.d[2] = $signed({cmd.target_z[FW-1], cmd.target_z})
			- $signed({cmd.eye_z[FW-1], cmd.eye_z});
		// eye on target: no forward direction, back end skips the maths
		job_c.fwd_zero = (job_c.d[0] == '0) && (job_c.d[1] == '0) && (job_c.d[2] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (cmd.ready)
			v_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid)
			job_s1 <= job_c;
	end

endmodule

// ===== rtl/lav_back.sv =====
`timescale 1ns / 1ps

module lav_back import lav_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  lav_job_t   job,
	output logic       job_pop,
	lav_out_if.source  mat
);

	localparam logic [2:0] B_IDLE   = 3'd0;
	localparam logic [2:0] B_NORMF  = 3'd1;
	localparam logic [2:0] B_CROSS  = 3'd2;
	localparam logic [2:0] B_NORMR  = 3'd3;
	localparam logic [2:0] B_UCROSS = 3'd4;
	localparam logic [2:0] B_DOT    = 3'd5;
	localparam logic [2:0] B_OUT    = 3'd6;

	localparam int CROSS_TERMS = 6;
	localparam int DOT_TERMS   = 9;
	localparam int CW          = $clog2(DOT_TERMS + 1);

	logic [2:0]              state_q;
	logic [CW-1:0]           cnt_q;
	logic                    norm_start_q;
	logic                    pv_s1;
	logic [1:0]              row_q;
	logic                    ovalid_q;

	q16_t                    eye_q [3];
	q16_t                    up_q [3];
	logic signed [DW-1:0]    d_q [3];
	logic signed [VW-1:0]    c_q [3];
	unit_t                   f_q [3];
	unit_t                   r_q [3];
	unit_t                   u_q [3];
	q16_t                    t_q [3];
	logic                    degen_q;
	logic signed [AW-1:0]    acc_q;
	logic signed [PW-1:0]    prod_s1;
	logic                    sub_s1;
	logic                    last_s1;
	logic [1:0]              grp_s1;

	logic [1:0]              orow_q;
	q16_t                    ocol_q [4];
	logic                    odegen_q;
	logic                    olast_q;

	logic [2:0][VW-1:0]      norm_v;
	lav_norm_res_t           norm_res;
	logic                    mac_st;
	logic                    issue;
	logic                    load;
	unit_t                   xa [3];
	logic signed [DW-1:0]    xb [3];
	unit_t                   op_a;
	logic signed [DW-1:0]    op_b;
	logic                    op_sub;
	logic                    op_last;
	logic [1:0]              op_grp;
	logic [1:0]              ia;
	logic [1:0]              ib;
	logic signed [AW-1:0]    pext;
	logic signed [AW-1:0]    sum_c;
	logic signed [RW-1:0]    rnd;
	unit_t                   rowv [3];

	lav_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start_q),
		.v      (norm_v),
		.res    (norm_res)
	);

	always_comb begin
		for (int i = 0; i < 3; i++)
			norm_v[i] = (state_q == B_NORMF) ? VW'(d_q[i]) : c_q[i];
	end

	assign job_pop = (state_q == B_IDLE) && job_valid;
	assign mac_st  = (state_q == B_CROSS) || (state_q == B_UCROSS) || (state_q == B_DOT);
	assign issue   = mac_st && (cnt_q < ((state_q == B_DOT) ? CW'(DOT_TERMS)
		: CW'(CROSS_TERMS)));
	assign load    = !ovalid_q || mat.ready;

	// operand decode for the shared multiplier
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (state_q == B_UCROSS) begin
				xa[i] = r_q[i];
				xb[i] = {{(DW-NW){f_q[i][NW-1]}}, f_q[i]};
			end else begin
				xa[i] = f_q[i];
				xb[i] = {up_q[i][FW-1], up_q[i]};
			end
		end
		ia      = 2'd0;
		ib      = 2'd0;
		op_sub  = 1'b0;
		op_last = 1'b0;
		op_grp  = 2'd0;
		if (state_q == B_DOT) begin
			case (cnt_q)
				CW'(0): begin op_grp = 2'd0; ib = 2'd0; end
				CW'(1): begin op_grp = 2'd0; ib = 2'd1; end
				CW'(2): begin op_grp = 2'd0; ib = 2'd2; end
				CW'(3): begin op_grp = 2'd1; ib = 2'd0; end
				CW'(4): begin op_grp = 2'd1; ib = 2'd1; end
				CW'(5): begin op_grp = 2'd1; ib = 2'd2; end
				CW'(6): begin op_grp = 2'd2; ib = 2'd0; end
				CW'(7): begin op_grp = 2'd2; ib = 2'd1; end
				default: begin op_grp = 2'd2; ib = 2'd2; end
			endcase
			op_last = (ib == 2'd2);
			ia      = ib;
		end else begin
			case (cnt_q)
				CW'(0): begin ia = 2'd1; ib = 2'd2; end
				CW'(1): begin ia = 2'd2; ib = 2'd1; op_sub = 1'b1; op_last = 1'b1; end
				CW'(2): begin ia = 2'd2; ib = 2'd0; op_grp = 2'd1; end
				CW'(3): begin
					ia = 2'd0; ib = 2'd2; op_sub = 1'b1; op_last = 1'b1; op_grp = 2'd1;
				end
				CW'(4): begin ia = 2'd0; ib = 2'd1; op_grp = 2'd2; end
				default: begin
					ia = 2'd1; ib = 2'd0; op_sub = 1'b1; op_last = 1'b1; op_grp = 2'd2;
				end
			endcase
		end
		for (int i = 0; i < 3; i++) begin
			case (row_q)
				2'd0:    rowv[i] = r_q[i];
				2'd1:    rowv[i] = u_q[i];
				default: rowv[i] = -f_q[i];
			endcase
		end
		if (state_q == B_DOT) begin
			case (op_grp)
				2'd0:    op_a = r_q[ia];
				2'd1:    op_a = u_q[ia];
				default: op_a = -f_q[ia];
			endcase
			op_b = {eye_q[ib][FW-1], eye_q[ib]};
		end else begin
			op_a = xa[ia];
			op_b = xb[ib];
		end
		pext  = AW'(prod_s1);
		sum_c = acc_q + (sub_s1 ? -pext : pext);
		rnd   = round_q16(sum_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			cnt_q        <= '0;
			norm_start_q <= 1'b0;
			pv_s1        <= 1'b0;
			row_q        <= '0;
			ovalid_q     <= 1'b0;
		end else begin
			norm_start_q <= 1'b0;
			pv_s1        <= issue;
			if (issue)
				cnt_q <= cnt_q + CW'(1);
			if (mat.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						if (job.fwd_zero)
							state_q <= B_OUT;
						else begin
							state_q      <= B_NORMF;
							norm_start_q <= 1'b1;
						end
					end
				end
				B_NORMF: begin
					if (norm_res.done) begin
						cnt_q   <= '0;
						state_q <= norm_res.zero ? B_OUT : B_CROSS;
					end
				end
				B_CROSS: begin
					if (cnt_q == CW'(CROSS_TERMS)) begin
						state_q      <= B_NORMR;
						norm_start_q <= 1'b1;
					end
				end
				B_NORMR: begin
					if (norm_res.done) begin
						cnt_q   <= '0;
						state_q <= norm_res.zero ? B_OUT : B_UCROSS;
					end
				end
				B_UCROSS: begin
					if (cnt_q == CW'(CROSS_TERMS)) begin
						cnt_q   <= '0;
						state_q <= B_DOT;
					end
				end
				B_DOT: begin
					if (cnt_q == CW'(DOT_TERMS))
						state_q <= B_OUT;
				end
				B_OUT: begin
					if (load) begin
						ovalid_q <= 1'b1;
						row_q    <= row_q + 2'd1;
						if (row_q == ROW_LAST)
							state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			for (int i = 0; i < 3; i++) begin
				eye_q[i] <= $signed(job.eye[i]);
				up_q[i]  <= $signed(job.up[i]);
				d_q[i]   <= $signed(job.d[i]);
			end
			degen_q <= job.fwd_zero;
		end
		if (state_q == B_NORMF && norm_res.done) begin
			for (int i = 0; i < 3; i++)
				f_q[i] <= $signed(norm_res.n[i]);
			if (norm_res.zero)
				degen_q <= 1'b1;
		end
		if (state_q == B_NORMR && norm_res.done) begin
			for (int i = 0; i < 3; i++)
				r_q[i] <= $signed(norm_res.n[i]);
			if (norm_res.zero)
				degen_q <= 1'b1;
		end

		prod_s1 <= op_a * op_b;
		sub_s1  <= op_sub;
		last_s1 <= op_last;
		grp_s1  <= op_grp;

		if (!mac_st)
			acc_q <= '0;
		else if (pv_s1)
			acc_q <= last_s1 ? '0 : sum_c;

		if (pv_s1 && last_s1) begin
			case (state_q)
				B_CROSS:  c_q[grp_s1] <= VW'(sum_c);
				B_UCROSS: u_q[grp_s1] <= NW'(rnd);
				default:  t_q[grp_s1] <= sat_q16(-rnd);
			endcase
		end

		if (state_q == B_OUT && load) begin
			orow_q   <= row_q;
			odegen_q <= degen_q;
			olast_q  <= (row_q == ROW_LAST);
			if (row_q == ROW_LAST) begin
				ocol_q[0] <= '0;
				ocol_q[1] <= '0;
				ocol_q[2] <= '0;
				ocol_q[3] <= ONE_Q16;
			end else if (degen_q) begin
				for (int i = 0; i < 4; i++)
					ocol_q[i] <= '0;
			end else begin
				for (int i = 0; i < 3; i++)
					ocol_q[i] <= {{(FW-NW){rowv[i][NW-1]}}, rowv[i]};
				ocol_q[3] <= t_q[row_q];
			end
		end
	end

	assign mat.valid      = ovalid_q;
	assign mat.row_index  = orow_q;
	assign mat.col0       = ocol_q[0];
	assign mat.col1       = ocol_q[1];
	assign mat.col2       = ocol_q[2];
	assign mat.col3       = ocol_q[3];
	assign mat.degenerate = odegen_q;
	assign mat.last       = olast_q;

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready && mat.last |-> mat.row_index == ROW_LAST)
		else $error("last marker off the final row");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.degenerate && !mat.last |->
		mat.col0 == '0 && mat.col1 == '0 && mat.col2 == '0 && mat.col3 == '0)
		else $error("degenerate rotation row not zero");

	a_norm_owner: assert property (@(posedge clk) disable iff (!arst_n)
		norm_res.done |-> state_q == B_NORMF || state_q == B_NORMR)
		else $error("normaliser finished with no request pending");

endmodule
